[src/bresenham_line_stepper_unit_defines.svh]
// Assertion macros of the line stepper RTL.
`ifndef BRESENHAM_LINE_STEPPER_UNIT_DEFINES_SVH
`define BRESENHAM_LINE_STEPPER_UNIT_DEFINES_SVH
`ifndef NO_ASSERTIONS
// Checked only while out of reset.
`define BLS_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// Checked at every edge, reset included.
`define BLS_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define BLS_ASSERT(lbl, clk, rst_n, prop, msg)
`define BLS_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif
`endif

[src/bls_pkg.sv]
// Shared types and constants of the line stepper.
`default_nettype none
package bls_pkg;

    localparam int COORD_BITS_DEF = 12;
    localparam int REG_W          = 13;
    localparam int INDEX_W        = 24;
    localparam int QUEUE_DEPTH    = 4;
    localparam int CFG_IDX_W      = 1;

    localparam logic [REG_W-1:0] WIDTH_RESET  = 13'd640;
    localparam logic [REG_W-1:0] HEIGHT_RESET = 13'd480;

    typedef enum logic
    {
        CMD_LOAD = 1'b0,
        CMD_STEP = 1'b1
    } cmd_t;

    typedef enum logic [CFG_IDX_W-1:0]
    {
        CFG_VIEW_WIDTH  = 1'b0,
        CFG_VIEW_HEIGHT = 1'b1
    } cfg_reg_t;

    // Decoded control of one queued item.
    typedef struct packed
    {
        logic is_load;
        logic active;
        logic step_left;
        logic step_down;
    } line_flags_t;

    // Viewport size as seen by the back end.
    typedef struct packed
    {
        logic [REG_W-1:0] width;
        logic [REG_W-1:0] height;
    } view_cfg_t;

    // Queue entry: flags, four coordinates, two deltas, initial error.
    function automatic int entry_width(input int coord_bits);
        return $bits(line_flags_t) + 4 * coord_bits + 2 * (coord_bits + 1)
               + (coord_bits + 3);
    endfunction

endpackage
`default_nettype wire

[src/bls_if.sv]
// Handshake channel interfaces of the line stepper.
`default_nettype none
interface bls_in_if #(parameter int COORD_BITS = bls_pkg::COORD_BITS_DEF);
    logic                         valid;
    logic                         ready;
    logic                         command;
    logic signed [COORD_BITS-1:0] start_x;
    logic signed [COORD_BITS-1:0] start_y;
    logic signed [COORD_BITS-1:0] end_x;
    logic signed [COORD_BITS-1:0] end_y;

    modport source (output valid, command, start_x, start_y, end_x, end_y, input ready);
    modport sink (input valid, command, start_x, start_y, end_x, end_y, output ready);
endinterface

interface bls_out_if #(parameter int COORD_BITS = bls_pkg::COORD_BITS_DEF);
    logic                             valid;
    logic                             ready;
    logic signed [COORD_BITS-1:0]     pixel_x;
    logic signed [COORD_BITS-1:0]     pixel_y;
    logic [bls_pkg::INDEX_W-1:0]      pixel_index;
    logic                             in_view;
    logic                             last;

    modport source (output valid, pixel_x, pixel_y, pixel_index, in_view, last, input ready);
    modport sink (input valid, pixel_x, pixel_y, pixel_index, in_view, last, output ready);
endinterface

interface bls_cfg_if;
    logic                          valid;
    logic                          ready;
    logic [bls_pkg::CFG_IDX_W-1:0] index;
    logic [bls_pkg::REG_W-1:0]     data;

    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface
`default_nettype wire

[src/bresenham_line_stepper_unit.sv]
// Top level of the Bresenham line stepper.
`default_nettype none
// Usage:
// The item channel takes commands. A load transfer (command 0) sets the start
// and end points and produces no pixel. Each step transfer (command 1) moves one
// pixel along the loaded line and yields one transfer on the pixel channel with
// the coordinates, the bottom-up frame buffer index, the in-view flag and a last
// mark on the end point. The start pixel is never produced, a zero-length line
// produces nothing, and steps with no active line are absorbed silently.
// The cfg channel writes viewport_width (index 0) and viewport_height (index 1);
// it is always ready and must only be used while the block is idle.
// Throughput is one item per clock while the pixel receiver does not stall.
// Each step transfer passes the front register, the queue, the stepping stage
// and the output register; the index multiply sits in the output register stage.
// When the pixel receiver stalls, the back end holds its pixels, the four-entry
// queue keeps filling and the item channel drops ready only once it is full.
// Reset clears the viewport to 640 by 480, empties the pipeline and the queue
// and leaves no line loaded.
module bresenham_line_stepper_unit #(
    parameter int COORD_BITS = bls_pkg::COORD_BITS_DEF
) (
    input  wire logic  clk,
    input  wire logic  rst_n,
    bls_cfg_if.sink    cfg,
    bls_in_if.sink     item,
    bls_out_if.source  pixel
);

    localparam int EW = bls_pkg::entry_width(COORD_BITS);

    logic [bls_pkg::REG_W-1:0] width_reg;
    logic [bls_pkg::REG_W-1:0] height_reg;
    bls_pkg::view_cfg_t        vcfg;

    logic [EW-1:0] f_entry;
    logic          f_valid;
    logic          f_ready;
    logic [EW-1:0] q_entry;
    logic          q_valid;
    logic          q_ready;

    // The configuration registers take every write, so the port never stalls.
    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= bls_pkg::WIDTH_RESET;
            height_reg <= bls_pkg::HEIGHT_RESET;
        end
        else if (cfg.valid)
        begin
            case (cfg.index)
                bls_pkg::CFG_VIEW_WIDTH:  width_reg  <= cfg.data;
                bls_pkg::CFG_VIEW_HEIGHT: height_reg <= cfg.data;
                default:                  ;
            endcase
        end
    end

    assign vcfg.width  = width_reg;
    assign vcfg.height = height_reg;

    // Front end registers each item and works out the setup of a load.
    bls_front #(
        .COORD_BITS (COORD_BITS)
    ) u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .item        (item),
        .entry       (f_entry),
        .entry_valid (f_valid),
        .entry_ready (f_ready)
    );

    // The queue lets the front keep taking items while the back is stalled.
    bls_queue #(
        .WIDTH (EW),
        .DEPTH (bls_pkg::QUEUE_DEPTH)
    ) u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_data  (f_entry),
        .wr_valid (f_valid),
        .wr_ready (f_ready),
        .rd_data  (q_entry),
        .rd_valid (q_valid),
        .rd_ready (q_ready)
    );

    // Back end steps the line and builds each pixel transfer.
    bls_back #(
        .COORD_BITS (COORD_BITS)
    ) u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .entry       (q_entry),
        .entry_valid (q_valid),
        .entry_ready (q_ready),
        .vcfg        (vcfg),
        .pixel       (pixel)
    );

endmodule
`default_nettype wire

[src/bls_front.sv]
// Front end: accepts items and precomputes the line setup of load commands.
`default_nettype none
module bls_front #(
    parameter int COORD_BITS = bls_pkg::COORD_BITS_DEF
) (
    input  wire logic                                        clk,
    input  wire logic                                        rst_n,
    bls_in_if.sink                                           item,
    output logic [bls_pkg::entry_width(COORD_BITS)-1:0]      entry,
    output logic                                             entry_valid,
    input  wire logic                                        entry_ready
);

    localparam int C  = COORD_BITS;
    localparam int EW = bls_pkg::entry_width(COORD_BITS);

    logic                  valid_reg;
    logic [EW-1:0]         entry_reg;
    logic [EW-1:0]         entry_next;
    logic                  accept;

    logic signed [C:0]     diff_x;
    logic signed [C:0]     diff_y;
    logic [C:0]            dx;
    logic [C:0]            dy;
    logic signed [C+2:0]   err_init;
    bls_pkg::line_flags_t  flags;

    assign item.ready = !valid_reg || entry_ready;
    assign accept     = item.valid && item.ready;

    // Signed difference start minus end; its sign gives the step direction.
    always_comb
    begin
        diff_x = (C+1)'(item.start_x) - (C+1)'(item.end_x);
        diff_y = (C+1)'(item.start_y) - (C+1)'(item.end_y);
        dx     = diff_x[C] ? (C+1)'(-diff_x) : (C+1)'(diff_x);
        dy     = diff_y[C] ? (C+1)'(-diff_y) : (C+1)'(diff_y);
        err_init = (C+3)'({2'b00, dx}) - (C+3)'({2'b00, dy});

        flags.is_load   = (item.command == bls_pkg::CMD_LOAD);
        flags.active    = (item.start_x != item.end_x) || (item.start_y != item.end_y);
        flags.step_left = !diff_x[C];
        flags.step_down = !diff_y[C];

        entry_next = {flags, item.start_x, item.start_y, item.end_x, item.end_y,
                      dx, dy, err_init};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (item.ready)
        begin
            valid_reg <= item.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            entry_reg <= entry_next;
        end
    end

    assign entry       = entry_reg;
    assign entry_valid = valid_reg;

endmodule
`default_nettype wire

[src/bls_queue.sv]
// Small FIFO between the front and back ends.
`default_nettype none
module bls_queue #(
    parameter int WIDTH = 8,
    parameter int DEPTH = bls_pkg::QUEUE_DEPTH
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic [WIDTH-1:0] wr_data,
    input  wire logic             wr_valid,
    output logic                  wr_ready,
    output logic [WIDTH-1:0]      rd_data,
    output logic                  rd_valid,
    input  wire logic             rd_ready
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);

    logic [WIDTH-1:0] slot_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [CNT_W-1:0] count_reg;
    logic             push;
    logic             pop;

    assign wr_ready = (count_reg != CNT_W'(DEPTH));
    assign rd_valid = (count_reg != '0);
    assign push     = wr_valid && wr_ready;
    assign pop      = rd_valid && rd_ready;
    assign rd_data  = slot_reg[rd_ptr_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (push && !pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (pop && !push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= wr_data;
        end
    end

endmodule
`default_nettype wire

[src/bls_back.sv]
// Back end: Bresenham stepping, viewport check and frame buffer index.
`default_nettype none
`include "bresenham_line_stepper_unit_defines.svh"
module bls_back #(
    parameter int COORD_BITS = bls_pkg::COORD_BITS_DEF
) (
    input  wire logic                                        clk,
    input  wire logic                                        rst_n,
    input  wire logic [bls_pkg::entry_width(COORD_BITS)-1:0] entry,
    input  wire logic                                        entry_valid,
    output logic                                             entry_ready,
    input  wire bls_pkg::view_cfg_t                          vcfg,
    bls_out_if.source                                        pixel
);

    localparam int C  = COORD_BITS;
    localparam int E  = C + 3;
    localparam int RW = bls_pkg::REG_W;
    localparam logic signed [C-1:0] ONE = C'(1);

    // Unpacked queue entry.
    bls_pkg::line_flags_t   e_flags;
    logic signed [C-1:0]    e_sx;
    logic signed [C-1:0]    e_sy;
    logic signed [C-1:0]    e_tx;
    logic signed [C-1:0]    e_ty;
    logic [C:0]             e_dx;
    logic [C:0]             e_dy;
    logic signed [E-1:0]    e_err;

    // Line state.
    logic signed [C-1:0]    cur_x_reg;
    logic signed [C-1:0]    cur_y_reg;
    logic signed [C-1:0]    tgt_x_reg;
    logic signed [C-1:0]    tgt_y_reg;
    logic [C:0]             dx_reg;
    logic [C:0]             dy_reg;
    logic                   left_reg;
    logic                   down_reg;
    logic signed [E-1:0]    err_reg;
    logic                   active_reg;

    // Stage one: the pixel just reached.
    logic                   p1_valid_reg;
    logic signed [C-1:0]    p1_x_reg;
    logic signed [C-1:0]    p1_y_reg;
    logic                   p1_last_reg;
    logic                   p1_view_reg;
    logic [RW-1:0]          p1_row_reg;
    logic [RW-1:0]          p1_col_reg;

    // Output register.
    logic                   out_valid_reg;
    logic signed [C-1:0]    out_x_reg;
    logic signed [C-1:0]    out_y_reg;
    logic [bls_pkg::INDEX_W-1:0] out_index_reg;
    logic                   out_view_reg;
    logic                   out_last_reg;

    logic                   out_adv;
    logic                   p1_free;
    logic                   pop;
    logic                   step_fire;

    logic signed [E:0]      e2;
    logic signed [E:0]      dx_s;
    logic signed [E:0]      dy_s;
    logic signed [E:0]      err_sum;
    logic                   move_x;
    logic                   move_y;
    logic signed [C-1:0]    nx;
    logic signed [C-1:0]    ny;
    logic                   at_end;
    logic [31:0]            xu;
    logic [31:0]            yu;
    logic                   view;
    logic [2*RW-1:0]        prod;
    logic [2*RW-1:0]        idx_sum;

    assign {e_flags, e_sx, e_sy, e_tx, e_ty, e_dx, e_dy, e_err} = entry;

    assign out_adv     = !out_valid_reg || pixel.ready;
    assign p1_free     = !p1_valid_reg || out_adv;
    assign entry_ready = p1_free;
    assign pop         = entry_valid && p1_free;
    assign step_fire   = pop && !e_flags.is_load && active_reg;

    // One Bresenham step from the current state.
    always_comb
    begin
        e2      = {err_reg, 1'b0};
        dx_s    = (E+1)'(dx_reg);
        dy_s    = (E+1)'(dy_reg);
        move_x  = e2 > -dy_s;
        move_y  = e2 < dx_s;
        err_sum = (E+1)'(err_reg) - (move_x ? dy_s : '0) + (move_y ? dx_s : '0);
        nx      = move_x ? (left_reg ? cur_x_reg - ONE : cur_x_reg + ONE) : cur_x_reg;
        ny      = move_y ? (down_reg ? cur_y_reg - ONE : cur_y_reg + ONE) : cur_y_reg;
        at_end  = (nx == tgt_x_reg) && (ny == tgt_y_reg);

        xu   = 32'(nx);
        yu   = 32'(ny);
        view = !nx[C-1] && !ny[C-1] && (xu < 32'(vcfg.width)) && (yu < 32'(vcfg.height));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg <= 1'b0;
        end
        else if (pop && e_flags.is_load)
        begin
            active_reg <= e_flags.active;
        end
        else if (step_fire)
        begin
            active_reg <= !at_end;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop && e_flags.is_load)
        begin
            cur_x_reg <= e_sx;
            cur_y_reg <= e_sy;
            tgt_x_reg <= e_tx;
            tgt_y_reg <= e_ty;
            dx_reg    <= e_dx;
            dy_reg    <= e_dy;
            left_reg  <= e_flags.step_left;
            down_reg  <= e_flags.step_down;
            err_reg   <= e_err;
        end
        else if (step_fire)
        begin
            cur_x_reg <= nx;
            cur_y_reg <= ny;
            err_reg   <= err_sum[E-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            p1_valid_reg <= 1'b0;
        end
        else if (p1_free)
        begin
            p1_valid_reg <= step_fire;
        end
    end

    always_ff @(posedge clk)
    begin
        if (step_fire)
        begin
            p1_x_reg    <= nx;
            p1_y_reg    <= ny;
            p1_last_reg <= at_end;
            p1_view_reg <= view;
            p1_col_reg  <= xu[RW-1:0];
            p1_row_reg  <= vcfg.height - RW'(1) - yu[RW-1:0];
        end
    end

    // Bottom-up row times width plus column, wrapped to the index width.
    always_comb
    begin
        prod    = p1_row_reg * vcfg.width;
        idx_sum = prod + (2*RW)'(p1_col_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_adv)
        begin
            out_valid_reg <= p1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_adv && p1_valid_reg)
        begin
            out_x_reg     <= p1_x_reg;
            out_y_reg     <= p1_y_reg;
            out_last_reg  <= p1_last_reg;
            out_view_reg  <= p1_view_reg;
            out_index_reg <= p1_view_reg ? idx_sum[bls_pkg::INDEX_W-1:0] : '0;
        end
    end

    assign pixel.valid       = out_valid_reg;
    assign pixel.pixel_x     = out_x_reg;
    assign pixel.pixel_y     = out_y_reg;
    assign pixel.pixel_index = out_index_reg;
    assign pixel.in_view     = out_view_reg;
    assign pixel.last        = out_last_reg;

    `BLS_ASSERT(a_last_ends_line, clk, rst_n, (step_fire && at_end) |=> !active_reg, "line still active after its end point")
    `BLS_ASSERT(a_p1_holds, clk, rst_n, (p1_valid_reg && !out_adv) |=> ($stable(p1_x_reg) && $stable(p1_y_reg) && p1_valid_reg), "stalled pixel stage changed")
    `BLS_ASSERT(a_out_from_p1, clk, rst_n, $rose(out_valid_reg) |-> $past(p1_valid_reg), "output valid without a staged pixel")
    `BLS_ASSERT_ALWAYS(a_reset_quiet, clk, !rst_n |-> (!out_valid_reg && !p1_valid_reg), "pipeline valid during reset")

endmodule
`default_nettype wire

[dv/tb_bresenham_line_stepper_unit.sv]
// Self-checking testbench of the line stepper: directed table, random lines, viewport sweep.
`timescale 1ns / 100ps
`default_nettype none
module tb_bresenham_line_stepper_unit;

    localparam int CB           = bls_pkg::COORD_BITS_DEF;
    localparam int ITEM_TARGET  = 1900;
    localparam int N_PHASES     = 8;
    // A load or an absorbed step may still be in the front register or the
    // queue when the last pixel leaves, so the block gets this many extra
    // cycles before a viewport write.
    localparam int SETTLE       = 12;
    localparam int LIMIT_CYCLES = 1_000_000;
    localparam int N_DIR        = 25;

    typedef logic signed [CB-1:0] coord_t;

    // One pixel as the block reports it.
    typedef struct packed
    {
        coord_t                      x;
        coord_t                      y;
        logic [bls_pkg::INDEX_W-1:0] fb_index;
        logic                        visible;
        logic                        at_end;
    } pixel_t;

    // One row of the directed table. When typed is set, want holds the pixel
    // that the row must produce; otherwise the line predictor decides.
    typedef struct
    {
        bls_pkg::cmd_t cmd;
        int            sx;
        int            sy;
        int            ex;
        int            ey;
        bit            typed;
        pixel_t        want;
    } drive_row_t;

    logic clk;
    logic rst_n;

    bls_cfg_if             cfg_ch ();
    bls_in_if  #(.COORD_BITS(CB)) item_ch ();
    bls_out_if #(.COORD_BITS(CB)) pix_ch ();

    bresenham_line_stepper_unit #(
        .COORD_BITS(CB)
    ) u_top (
        .clk   (clk),
        .rst_n (rst_n),
        .cfg   (cfg_ch),
        .item  (item_ch),
        .pixel (pix_ch)
    );

    // Line stepper state as the predictor tracks it.
    int                        cur_x;
    int                        cur_y;
    int                        tgt_x;
    int                        tgt_y;
    int                        span_x;
    int                        span_y;
    bit                        go_left;
    bit                        go_down;
    int                        err_acc;
    bit                        line_live;
    logic [bls_pkg::REG_W-1:0] view_w;
    logic [bls_pkg::REG_W-1:0] view_h;

    // Pixels that the block still owes, oldest first.
    pixel_t pixels_due [$];

    int  mismatches;
    int  n_loads;
    int  n_pixels;
    int  n_visible;
    int  n_line_ends;
    int  n_absorbed;
    int  n_counted;
    bit  src_burst;
    bit  sink_burst;

    // The directed table walks the special cases first: steps with nothing
    // loaded, a zero-length line, single-pixel lines at the corners of the
    // viewport and at both ends of the coordinate range, then a few lines in
    // other octants that the predictor checks.
    drive_row_t dir_rows [N_DIR] = '{
        '{bls_pkg::CMD_STEP, 0, 0, 0, 0, 1'b0, '0},
        '{bls_pkg::CMD_LOAD, 0, 0, 0, 0, 1'b0, '0},
        '{bls_pkg::CMD_STEP, 0, 0, 0, 0, 1'b0, '0},
        '{bls_pkg::CMD_LOAD, 0, 0, 1, 0, 1'b0, '0},
        '{bls_pkg::CMD_STEP, 0, 0, 0, 0, 1'b1,
          '{12'sd1, 12'sd0, 24'd306561, 1'b1, 1'b1}},
        '{bls_pkg::CMD_STEP, 0, 0, 0, 0, 1'b0, '0},
        '{bls_pkg::CMD_LOAD, 2047, 2047, 2046, 2046, 1'b0, '0},
        '{bls_pkg::CMD_STEP, -1, -1, -1, -1, 1'b1,
          '{12'sd2046, 12'sd2046, 24'd0, 1'b0, 1'b1}},
        '{bls_pkg::CMD_LOAD, -2048, -2048, -2047, -2048, 1'b0, '0},
        '{bls_pkg::CMD_STEP, 0, 0, 0, 0, 1'b1,
          '{-12'sd2047, -12'sd2048, 24'd0, 1'b0, 1'b1}},
        '{bls_pkg::CMD_LOAD, 639, 478, 639, 479, 1'b0, '0},
        '{bls_pkg::CMD_STEP, 0, 0, 0, 0, 1'b1,
          '{12'sd639, 12'sd479, 24'd639, 1'b1, 1'b1}},
        '{bls_pkg::CMD_LOAD, 0, 1, 0, 0, 1'b0, '0},
        '{bls_pkg::CMD_STEP, 0, 0, 0, 0, 1'b1,
          '{12'sd0, 12'sd0, 24'd306560, 1'b1, 1'b1}},
        '{bls_pkg::CMD_LOAD, 640, 0, 639, 0, 1'b0, '0},
        '{bls_pkg::CMD_STEP, 0, 0, 0, 0, 1'b1,
          '{12'sd639, 12'sd0, 24'd307199, 1'b1, 1'b1}},
        '{bls_pkg::CMD_LOAD, 5, 5, 1, 8, 1'b0, '0},
        '{bls_pkg::CMD_STEP, 0, 0, 0, 0, 1'b0, '0},
        '{bls_pkg::CMD_STEP, 0, 0, 0, 0, 1'b0, '0},
        '{bls_pkg::CMD_STEP, 0, 0, 0, 0, 1'b0, '0},
        '{bls_pkg::CMD_STEP, 0, 0, 0, 0, 1'b0, '0},
        '{bls_pkg::CMD_LOAD, 3, 3, 6, -2, 1'b0, '0},
        '{bls_pkg::CMD_STEP, 0, 0, 0, 0, 1'b0, '0},
        '{bls_pkg::CMD_STEP, 0, 0, 0, 0, 1'b0, '0},
        '{bls_pkg::CMD_STEP, 0, 0, 0, 0, 1'b0, '0}
    };

    // Appends one pixel to the list of pixels the block owes.
    function automatic void owe_pixel(input pixel_t px);
        pixels_due.insert(pixels_due.size(), px);
    endfunction

    // Applies one accepted item to the predicted line state. Returns 1 and
    // the pixel when the item moves along an active line.
    function automatic bit advance_line(input bls_pkg::cmd_t cmd, input coord_t sx,
                                        input coord_t sy, input coord_t ex,
                                        input coord_t ey, output pixel_t px);
        int          e2;
        longint      row;
        logic [63:0] prod;
        px = '0;
        if (cmd == bls_pkg::CMD_LOAD)
        begin
            cur_x     = sx;
            cur_y     = sy;
            tgt_x     = ex;
            tgt_y     = ey;
            span_x    = (cur_x > tgt_x) ? cur_x - tgt_x : tgt_x - cur_x;
            span_y    = (cur_y > tgt_y) ? cur_y - tgt_y : tgt_y - cur_y;
            go_left   = !(cur_x < tgt_x);
            go_down   = !(cur_y < tgt_y);
            err_acc   = span_x - span_y;
            line_live = (cur_x != tgt_x) || (cur_y != tgt_y);
            return 1'b0;
        end
        if (!line_live)
            return 1'b0;
        // Classic Bresenham: both tests use the error before either update.
        e2 = 2 * err_acc;
        if (e2 > -span_y)
        begin
            err_acc -= span_y;
            cur_x   += go_left ? -1 : 1;
        end
        if (e2 < span_x)
        begin
            err_acc += span_x;
            cur_y   += go_down ? -1 : 1;
        end
        px.x       = coord_t'(cur_x);
        px.y       = coord_t'(cur_y);
        px.visible = (cur_x >= 0) && (cur_y >= 0) && (cur_x < int'(view_w))
                     && (cur_y < int'(view_h));
        // Rows are stored bottom-up; large viewports wrap the index.
        if (px.visible)
        begin
            row         = longint'(view_h) - 1 - cur_y;
            prod        = row * longint'(view_w) + cur_x;
            px.fb_index = prod[bls_pkg::INDEX_W-1:0];
        end
        px.at_end = (cur_x == tgt_x) && (cur_y == tgt_y);
        if (px.at_end)
            line_live = 1'b0;
        return 1'b1;
    endfunction

    function automatic int clamp_coord(input int v);
        if (v > 2047)
            return 2047;
        if (v < -2048)
            return -2048;
        return v;
    endfunction

    function automatic int rand_coord();
        int v;
        v = $urandom_range(0, 4095);
        return v - 2048;
    endfunction

    // A coordinate close to the viewport's edges, so that lines cross in and
    // out of view often.
    function automatic int coord_near_view(input int lim);
        int hi;
        int base;
        int off;
        hi = (lim > 2048) ? 2048 : lim;
        case ($urandom_range(0, 3))
            0: base = 0;
            1: base = hi - 1;
            2: base = (hi > 0) ? $urandom_range(0, hi - 1) : 0;
            default: base = rand_coord();
        endcase
        off = $urandom_range(0, 24);
        return clamp_coord(base + off - 12);
    endfunction

    function automatic int line_length(input int sx, input int sy, input int ex, input int ey);
        int ax;
        int ay;
        ax = (sx > ex) ? sx - ex : ex - sx;
        ay = (sy > ey) ? sy - ey : ey - sy;
        return (ax > ay) ? ax : ay;
    endfunction

    // Offers one item after a random gap, waits for its transfer and records
    // what the block now owes.
    task automatic send_item(input bls_pkg::cmd_t cmd, input int sx, input int sy,
                             input int ex, input int ey, input bit typed,
                             input pixel_t want);
        coord_t csx;
        coord_t csy;
        coord_t cex;
        coord_t cey;
        pixel_t got;
        bit     produced;
        int     gap;
        csx = coord_t'(sx);
        csy = coord_t'(sy);
        cex = coord_t'(ex);
        cey = coord_t'(ey);
        if ($urandom_range(0, 11) == 0)
            src_burst = !src_burst;
        gap = src_burst ? 0 : $urandom_range(0, 9);
        if (gap > 0)
        begin
            item_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        item_ch.valid   <= 1'b1;
        item_ch.command <= cmd;
        item_ch.start_x <= csx;
        item_ch.start_y <= csy;
        item_ch.end_x   <= cex;
        item_ch.end_y   <= cey;
        do
            @(posedge clk);
        while (!(item_ch.valid && item_ch.ready));
        produced = advance_line(cmd, csx, csy, cex, cey, got);
        if (typed)
            owe_pixel(want);
        else if (produced)
            owe_pixel(got);
        if (cmd == bls_pkg::CMD_LOAD)
            n_loads++;
        if (cmd == bls_pkg::CMD_LOAD || produced)
            n_counted++;
        else
            n_absorbed++;
    endtask

    // Holds the sender until every owed pixel has arrived and the pipeline
    // has emptied of loads and absorbed steps.
    task automatic wait_idle();
        item_ch.valid <= 1'b0;
        do
            @(posedge clk);
        while (pixels_due.size() != 0);
        repeat (SETTLE) @(posedge clk);
    endtask

    // Writes both viewport registers back to back; the block must be idle.
    task automatic write_view(input int w, input int h);
        cfg_ch.index <= bls_pkg::CFG_VIEW_WIDTH;
        cfg_ch.data  <= bls_pkg::REG_W'(w);
        cfg_ch.valid <= 1'b1;
        do
            @(posedge clk);
        while (!(cfg_ch.valid && cfg_ch.ready));
        view_w = bls_pkg::REG_W'(w);
        cfg_ch.index <= bls_pkg::CFG_VIEW_HEIGHT;
        cfg_ch.data  <= bls_pkg::REG_W'(h);
        do
            @(posedge clk);
        while (!(cfg_ch.valid && cfg_ch.ready));
        view_h = bls_pkg::REG_W'(h);
        cfg_ch.valid <= 1'b0;
    endtask

    // Random lines under one viewport setting. Most are short, complete lines
    // near the viewport; the rest are longer lines, zero-length loads, lines
    // cut short by a new load and stray steps.
    task automatic run_phase(input int quota);
        int start_count;
        int kind;
        int sx;
        int sy;
        int ex;
        int ey;
        int reach;
        int n_steps;
        int dx;
        int dy;
        start_count = n_counted;
        while (n_counted - start_count < quota)
        begin
            kind = $urandom_range(0, 99);
            sx   = coord_near_view(int'(view_w));
            sy   = coord_near_view(int'(view_h));
            reach = (kind < 60) ? 15 : 120;
            dx   = $urandom_range(0, 2 * reach);
            dy   = $urandom_range(0, 2 * reach);
            ex   = clamp_coord(sx + dx - reach);
            ey   = clamp_coord(sy + dy - reach);
            if (kind < 72)
            begin
                // A complete line, sometimes with stray steps past its end.
                n_steps = line_length(sx, sy, ex, ey);
                if ($urandom_range(0, 3) == 0)
                    n_steps += $urandom_range(1, 2);
            end
            else if (kind < 80)
            begin
                ex      = sx;
                ey      = sy;
                n_steps = $urandom_range(0, 2);
            end
            else if (kind < 95)
            begin
                // Full-range endpoints, abandoned after a few pixels.
                sx      = rand_coord();
                sy      = rand_coord();
                ex      = rand_coord();
                ey      = rand_coord();
                n_steps = $urandom_range(0, 10);
            end
            else
            begin
                n_steps = $urandom_range(1, 4);
            end
            if (kind < 95)
                send_item(bls_pkg::CMD_LOAD, sx, sy, ex, ey, 1'b0, '0);
            repeat (n_steps)
                send_item(bls_pkg::CMD_STEP, rand_coord(), rand_coord(), rand_coord(),
                          rand_coord(), 1'b0, '0);
            if ($urandom_range(0, 59) == 0)
                wait_idle();
        end
    endtask

    task automatic compare_field(input string name, input longint want, input longint got);
        if (want != got)
        begin
            mismatches++;
            $display("%0t: pixel %s mismatch, expected %0d, actual %0d",
                     $realtime, name, want, got);
        end
    endtask

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    initial
    begin
        #(LIMIT_CYCLES * 4);
        $display("%0t: timeout with %0d pixels still owed", $realtime, pixels_due.size());
        $display("== FAIL ==");
        $finish;
    end

    // Every pixel transfer is checked against the oldest owed pixel. Values are
    // sampled as they stood before the edge.
    always @(posedge clk)
    begin
        pixel_t want;
        if (rst_n && pix_ch.valid && pix_ch.ready)
        begin
            if (pixels_due.size() == 0)
            begin
                mismatches++;
                $display("%0t: unexpected pixel, expected none, actual x=%0d y=%0d",
                         $realtime, pix_ch.pixel_x, pix_ch.pixel_y);
            end
            else
            begin
                want = pixels_due.pop_front();
                compare_field("x", want.x, pix_ch.pixel_x);
                compare_field("y", want.y, pix_ch.pixel_y);
                compare_field("index", want.fb_index, pix_ch.pixel_index);
                compare_field("in_view", want.visible, pix_ch.in_view);
                compare_field("last", want.at_end, pix_ch.last);
                n_pixels++;
                if (want.visible)
                    n_visible++;
                if (want.at_end)
                    n_line_ends++;
            end
        end
    end

    // Pixel receiver: stalls a random number of cycles before each transfer,
    // with stretches where it never stalls.
    initial
    begin
        int stall;
        pix_ch.ready <= 1'b0;
        sink_burst = 1'b0;
        do
            @(posedge clk);
        while (!rst_n);
        forever
        begin
            if ($urandom_range(0, 15) == 0)
                sink_burst = !sink_burst;
            stall = sink_burst ? 0 : $urandom_range(0, 9);
            if (stall > 0)
            begin
                pix_ch.ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            pix_ch.ready <= 1'b1;
            do
                @(posedge clk);
            while (!(pix_ch.valid && pix_ch.ready));
        end
    end

    // Main sequence: reset, directed table, then one random phase per
    // viewport setting, the extremes among them, ending on the reset values.
    initial
    begin
        int views [N_PHASES][2];
        int quota;
        mismatches  = 0;
        n_loads     = 0;
        n_pixels    = 0;
        n_visible   = 0;
        n_line_ends = 0;
        n_absorbed  = 0;
        n_counted   = 0;
        src_burst   = 1'b0;
        cur_x       = 0;
        cur_y       = 0;
        tgt_x       = 0;
        tgt_y       = 0;
        span_x      = 0;
        span_y      = 0;
        go_left     = 1'b0;
        go_down     = 1'b0;
        err_acc     = 0;
        line_live   = 1'b0;
        view_w      = bls_pkg::WIDTH_RESET;
        view_h      = bls_pkg::HEIGHT_RESET;
        views = '{'{1, 1}, '{4096, 4096}, '{0, 0}, '{8191, 8191}, '{320, 200},
                  '{0, 37}, '{1, 1}, '{640, 480}};
        views[6][0] = $urandom_range(1, 4096);
        views[6][1] = $urandom_range(1, 4096);

        rst_n           <= 1'b0;
        item_ch.valid   <= 1'b0;
        item_ch.command <= bls_pkg::CMD_LOAD;
        item_ch.start_x <= '0;
        item_ch.start_y <= '0;
        item_ch.end_x   <= '0;
        item_ch.end_y   <= '0;
        cfg_ch.valid    <= 1'b0;
        cfg_ch.index    <= bls_pkg::CFG_VIEW_WIDTH;
        cfg_ch.data     <= '0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (int i = 0; i < N_DIR; i++)
            send_item(dir_rows[i].cmd, dir_rows[i].sx, dir_rows[i].sy, dir_rows[i].ex,
                      dir_rows[i].ey, dir_rows[i].typed, dir_rows[i].want);

        quota = (ITEM_TARGET - n_counted) / N_PHASES;
        for (int p = 0; p < N_PHASES; p++)
        begin
            wait_idle();
            write_view(views[p][0], views[p][1]);
            run_phase(quota);
        end

        // Drain, then give the block time to show any pixel it should not.
        item_ch.valid <= 1'b0;
        do
            @(posedge clk);
        while (pixels_due.size() != 0);
        repeat (20) @(posedge clk);

        $display("Drove %0d loads and %0d absorbed steps; checked %0d pixels, %0d in view.",
                 n_loads, n_absorbed, n_pixels, n_visible);
        $display("Finished %0d lines across %0d viewport sizes, zero and 8191 included.",
                 n_line_ends, N_PHASES);
        if (mismatches == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
`default_nettype wire

[bresenham_line_stepper_unit.f]
+incdir+src
src/bls_pkg.sv
src/bls_if.sv
src/bls_front.sv
src/bls_queue.sv
src/bls_back.sv
src/bresenham_line_stepper_unit.sv
dv/tb_bresenham_line_stepper_unit.sv
